>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for concurrent assertions on clk with active-low reset arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define CHK_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CHK_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/dqap_pkg.sv
// ----------------------------------------------------------------------------
// dqap_pkg
// Types and constants of the dotted-quad address parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dqap_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned StatusW = 2;
	localparam int unsigned AddrW   = 32;

	localparam logic [ByteW-1:0] CH_NUL  = 8'h00;
	localparam logic [ByteW-1:0] CH_DOT  = 8'h2E;
	localparam logic [ByteW-1:0] CH_ZERO = 8'h30;
	localparam logic [ByteW-1:0] CH_NINE = 8'h39;

	// Octet accumulator is wide enough for 255 * 10 + 9.
	localparam int unsigned AccW = 12;
	localparam logic [AccW-1:0] OCTET_LIMIT = 12'd256;
	localparam logic [AccW-1:0] RADIX       = 12'd10;
	localparam logic [1:0]      LAST_OCTET  = 2'd3;

	localparam logic [StatusW-1:0] ST_PARSED    = 2'd0;
	localparam logic [StatusW-1:0] ST_EMPTY     = 2'd1;
	localparam logic [StatusW-1:0] ST_NONNUM    = 2'd2;
	localparam logic [StatusW-1:0] ST_MALFORMED = 2'd3;

	typedef struct packed {
		logic [StatusW-1:0] status;
		logic [AddrW-1:0]   address;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/core/dotted_quad_address_parser.sv
// ----------------------------------------------------------------------------
// dotted_quad_address_parser
// Classifies a zero-terminated host name and parses dotted-quad addresses.
// ----------------------------------------------------------------------------
// Path: an accepted zero byte is held in the input stage, then its result is loaded into the result register.
// Throughput: one byte per cycle; bytes flow while a result waits, and only a
// zero byte stalls when the result register is still occupied.
// Reset: arst_n clears the input stage, the parse state and the result valid.
`default_nettype none

module dotted_quad_address_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [31:0] m_axis_tdata,   // [31:0] address
	output      logic [1:0]  m_axis_tuser    // [1:0] status
);
	import dqap_pkg::*;

	logic       in_valid_s1;
	logic [7:0] in_byte_s1;
	logic       advance;
	logic       done;
	logic       out_free;
	result_t    result;

	// A zero byte may only leave the input stage when the result register can take it.
	assign advance       = in_valid_s1 && (!done || out_free);
	assign s_axis_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			in_byte_s1 <= s_axis_tdata;
		end
	end

	dqap_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.text_byte (in_byte_s1),
		.done      (done),
		.result    (result)
	);

	dqap_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance && done),
		.result        (result),
		.free          (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

`default_nettype wire

>>> rtl/core/dqap_scan.sv
// ----------------------------------------------------------------------------
// dqap_scan
// Per-name parse state and the classification of a name at its end byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dqap_scan (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   step,
	input  wire logic [7:0]             text_byte,
	output      logic                   done,
	output      dqap_pkg::result_t      result
);
	import dqap_pkg::*;

	logic [1:0]      octet_index_q;
	logic [7:0]      octet_value_q;
	logic            digit_seen_q;
	logic            malformed_q;
	logic            foreign_q;
	logic            any_byte_q;
	logic [23:0]     finished_q;

	logic            is_digit;
	logic            is_dot;
	logic [AccW-1:0] next_val;
	logic            overflow;

	assign done     = (text_byte == CH_NUL);
	assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
	assign is_dot   = (text_byte == CH_DOT);
	assign next_val = AccW'(octet_value_q) * RADIX + AccW'(text_byte - CH_ZERO);
	assign overflow = (next_val >= OCTET_LIMIT);

	always_comb begin
		result.address = '0;
		if (!any_byte_q) begin
			result.status = ST_EMPTY;
		end else if (foreign_q) begin
			result.status = ST_NONNUM;
		end else if (malformed_q || octet_index_q != LAST_OCTET || !digit_seen_q) begin
			result.status = ST_MALFORMED;
		end else begin
			result.status  = ST_PARSED;
			result.address = {finished_q, octet_value_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octet_index_q <= '0;
			octet_value_q <= '0;
			digit_seen_q  <= 1'b0;
			malformed_q   <= 1'b0;
			foreign_q     <= 1'b0;
			any_byte_q    <= 1'b0;
			finished_q    <= '0;
		end else if (step) begin
			if (done) begin
				octet_index_q <= '0;
				octet_value_q <= '0;
				digit_seen_q  <= 1'b0;
				malformed_q   <= 1'b0;
				foreign_q     <= 1'b0;
				any_byte_q    <= 1'b0;
				finished_q    <= '0;
			end else begin
				any_byte_q <= 1'b1;
				if (is_digit) begin
					if (!malformed_q) begin
						if (overflow) begin
							malformed_q <= 1'b1;
						end else begin
							octet_value_q <= next_val[7:0];
							digit_seen_q  <= 1'b1;
						end
					end
				end else if (is_dot) begin
					if (!malformed_q) begin
						if (!digit_seen_q || octet_index_q == LAST_OCTET) begin
							malformed_q <= 1'b1;
						end else begin
							finished_q    <= {finished_q[15:0], octet_value_q};
							octet_index_q <= octet_index_q + 2'd1;
							octet_value_q <= '0;
							digit_seen_q  <= 1'b0;
						end
					end
				end else begin
					foreign_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/dqap_out_reg.sv
// ----------------------------------------------------------------------------
// dqap_out_reg
// Result register driving the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module dqap_out_reg (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load,
	input  wire dqap_pkg::result_t    result,
	output      logic                 free,
	output      logic                 m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output      logic [31:0]          m_axis_tdata,
	output      logic [1:0]           m_axis_tuser
);
	import dqap_pkg::*;

	logic    out_valid_q;
	result_t out_res_q;

	assign free          = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_res_q.address;
	assign m_axis_tuser  = out_res_q.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (free) begin
			out_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			out_res_q <= result;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/dqap_checker.sv
// ----------------------------------------------------------------------------
// dqap_checker
// Port-level checks of the dotted-quad address parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dqap_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [7:0]  s_axis_tdata,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser
);
	import dqap_pkg::*;

	logic in_beat;
	assign in_beat = s_axis_tvalid && s_axis_tready && (s_axis_tdata == CH_NUL);

	// Only a parsed address carries a nonzero address.
	`CHK_ASSERT(a_addr_zero, m_axis_tvalid && m_axis_tuser != ST_PARSED |-> m_axis_tdata == '0, "address nonzero for a non-parsed status")

	// A stalled result beat holds its contents.
	`CHK_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result beat changed")

	// Reset empties the result register and opens the input.
	`CHK_ASSERT_ALWAYS(a_reset_out, !arst_n |-> !m_axis_tvalid, "result valid during reset")

	// The input stage is empty right after reset, so the first cycle accepts.
	`CHK_ASSERT(a_ready_after_reset, $past(!arst_n) |-> s_axis_tready, "input not ready after reset")

	// An end byte taken with the output idle yields a result beat after the input stage.
	`CHK_ASSERT(a_latency, in_beat && !m_axis_tvalid |=> ##1 m_axis_tvalid, "no result beat two cycles after its end byte")

endmodule

bind dotted_quad_address_parser dqap_checker u_dqap_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
